@@ rtl/tthg_pkg.sv @@
package tthg_pkg;

	typedef enum logic [1:0] {
		OP_TOUCH = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [1:0] CFG_GAP      = 2'd1;
	localparam logic [1:0] CFG_HOLD     = 2'd2;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [15:0] GAP_RESET      = 16'd300;
	localparam logic [15:0] HOLD_RESET     = 16'd1000;

	localparam int CLR_TAP    = 0;
	localparam int CLR_DOUBLE = 1;
	localparam int CLR_HOLD   = 2;

	localparam logic [2:0] COUNT_NONE = 3'd0;
	localparam logic [2:0] COUNT_ONE  = 3'd1;
	localparam logic [2:0] COUNT_TWO  = 3'd2;

	typedef struct packed {
		logic touching;
		logic was_touching;
		logic tap_allowed;
		logic ignore_release;
		logic double_on_release;
		logic awaiting_second;
		logic tap_latch;
		logic double_latch;
		logic hold_latch;
	} flags_t;

endpackage

@@ rtl/tthg_eval.sv @@
module tthg_eval #(
	parameter int TIME_WIDTH = 32
) (
	input  tthg_pkg::flags_t        flags_i,
	input  logic [TIME_WIDTH-1:0]   cur_time,
	input  logic [TIME_WIDTH-1:0]   rel_time,
	input  logic [TIME_WIDTH-1:0]   prs_time,
	input  logic [15:0]             debounce,
	input  logic [15:0]             gap,
	input  logic [15:0]             hold,
	output tthg_pkg::flags_t        flags_o,
	output logic [TIME_WIDTH-1:0]   rel_time_nxt,
	output logic [TIME_WIDTH-1:0]   prs_time_nxt
);
	import tthg_pkg::*;

	logic [63:0]           deb_w, gap_w, hold_w;
	logic [TIME_WIDTH-1:0] deb_t, gap_t, hold_t;
	logic [TIME_WIDTH-1:0] since_rel, since_prs;
	logic [TIME_WIDTH-1:0] since_rel2, since_prs2;
	logic                  press, release_ok;

	assign deb_w  = {48'd0, debounce};
	assign gap_w  = {48'd0, gap};
	assign hold_w = {48'd0, hold};
	assign deb_t  = deb_w[TIME_WIDTH-1:0];
	assign gap_t  = gap_w[TIME_WIDTH-1:0];
	assign hold_t = hold_w[TIME_WIDTH-1:0];

	assign since_rel = cur_time - rel_time;
	assign since_prs = cur_time - prs_time;

	assign press      = flags_i.touching && !flags_i.was_touching && (since_rel > deb_t);
	assign release_ok = !flags_i.touching && flags_i.was_touching && (since_prs > deb_t)
		&& !flags_i.ignore_release;

	// A time stamp that is rewritten to the current time makes its distance zero, so the
	// second set of distances needs no further subtraction.
	always_comb begin
		flags_o      = flags_i;
		rel_time_nxt = rel_time;
		prs_time_nxt = prs_time;
		since_rel2   = since_rel;
		since_prs2   = since_prs;
		if (press) begin
			prs_time_nxt              = cur_time;
			since_prs2                = '0;
			flags_o.ignore_release    = 1'b0;
			flags_o.tap_allowed       = 1'b1;
			flags_o.double_on_release = (since_rel < gap_t) && !flags_i.double_on_release
				&& flags_i.awaiting_second;
			flags_o.awaiting_second   = 1'b0;
		end else if (release_ok) begin
			rel_time_nxt = cur_time;
			since_rel2   = '0;
			if (!flags_i.double_on_release) begin
				flags_o.awaiting_second = 1'b1;
			end else begin
				flags_o.double_latch      = 1'b1;
				flags_o.double_on_release = 1'b0;
				flags_o.awaiting_second   = 1'b0;
				flags_o.tap_allowed       = 1'b0;
			end
		end

		if (!flags_o.touching && (since_rel2 >= gap_t) && flags_o.awaiting_second
			&& !flags_o.double_on_release && flags_o.tap_allowed) begin
			flags_o.tap_latch       = 1'b1;
			flags_o.awaiting_second = 1'b0;
		end

		if (flags_o.touching && !flags_o.hold_latch && (since_prs2 > hold_t)) begin
			flags_o.hold_latch        = 1'b1;
			flags_o.ignore_release    = 1'b1;
			flags_o.double_on_release = 1'b0;
			flags_o.awaiting_second   = 1'b0;
		end

		flags_o.was_touching = flags_o.touching;
	end

endmodule

@@ rtl/touch_tap_hold_gesture_detector.sv @@
// Tap, double-tap and hold detector for a single finger. Each input transfer (touch
// report, time tick or flag clear) produces exactly one result transfer carrying the
// latched tap, double-tap and hold flags and the finger state. One item is taken every
// cycle unless a held-up result stalls the input. Each item passes an input register and
// a result register, with all gesture evaluation combinational between them. Configuration
// writes take effect from the next cycle and should only be made while the block is idle.
module touch_tap_hold_gesture_detector #(
	parameter int TIME_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [2:0]  finger_count,
	input  logic [31:0] event_time,
	input  logic [2:0]  clear_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tap_flag,
	output logic        double_tap_flag,
	output logic        hold_flag,
	output logic        finger_down
);
	import tthg_pkg::*;

	logic [15:0] debounce_q, gap_q, hold_q;

	logic        valid_s1;
	logic [1:0]  opcode_s1;
	logic [2:0]  count_s1;
	logic [31:0] time_s1;
	logic [2:0]  mask_s1;

	logic                  out_valid_q;
	logic                  tap_q, double_q, hold_q_flag, finger_q;

	flags_t                flags_q, ev_flags, eval_flags, nxt_flags;
	logic [2:0]            prev_count_q, nxt_prev;
	logic [TIME_WIDTH-1:0] cur_time_q, rel_time_q, prs_time_q;
	logic [TIME_WIDTH-1:0] ev_cur, nxt_cur, eval_rel, eval_prs, nxt_rel, nxt_prs;
	logic [TIME_WIDTH-1:0] etime;
	logic [63:0]           etime_w;
	logic                  do_eval;
	logic                  advance;

	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			gap_q      <= GAP_RESET;
			hold_q     <= HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data;
				CFG_GAP:      gap_q      <= cfg_data;
				CFG_HOLD:     hold_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			count_s1  <= finger_count;
			time_s1   <= event_time;
			mask_s1   <= clear_mask;
		end
	end

	assign etime_w = {32'd0, time_s1};
	assign etime   = etime_w[TIME_WIDTH-1:0];

	// Decide what the evaluation sees; a release is judged at the stored current time.
	always_comb begin
		ev_flags = flags_q;
		ev_cur   = cur_time_q;
		do_eval  = 1'b0;
		case (opcode_s1)
			OP_TOUCH: begin
				if (count_s1 == COUNT_NONE) begin
					if (prev_count_q == COUNT_ONE) begin
						ev_flags.touching = 1'b0;
						do_eval           = 1'b1;
					end
				end else if (count_s1 == COUNT_ONE) begin
					ev_flags.touching = 1'b1;
					ev_cur            = etime;
					do_eval           = 1'b1;
				end
			end
			OP_TICK: begin
				if (!flags_q.touching && flags_q.awaiting_second && flags_q.tap_allowed) begin
					ev_cur  = etime;
					do_eval = 1'b1;
				end
			end
			default: ;
		endcase
	end

	tthg_eval #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_eval (
		.flags_i      (ev_flags),
		.cur_time     (ev_cur),
		.rel_time     (rel_time_q),
		.prs_time     (prs_time_q),
		.debounce     (debounce_q),
		.gap          (gap_q),
		.hold         (hold_q),
		.flags_o      (eval_flags),
		.rel_time_nxt (eval_rel),
		.prs_time_nxt (eval_prs)
	);

	always_comb begin
		nxt_flags = flags_q;
		nxt_prev  = prev_count_q;
		nxt_cur   = cur_time_q;
		nxt_rel   = rel_time_q;
		nxt_prs   = prs_time_q;
		case (opcode_s1)
			OP_TOUCH: begin
				nxt_prev = count_s1;
				if (count_s1 == COUNT_ONE || count_s1 == COUNT_TWO) begin
					nxt_cur = etime;
				end
			end
			OP_TICK: begin
				nxt_cur = ev_cur;
			end
			OP_CLEAR: begin
				if (mask_s1[CLR_TAP])    nxt_flags.tap_latch    = 1'b0;
				if (mask_s1[CLR_DOUBLE]) nxt_flags.double_latch = 1'b0;
				if (mask_s1[CLR_HOLD])   nxt_flags.hold_latch   = 1'b0;
			end
			default: ;
		endcase
		if (do_eval) begin
			nxt_flags = eval_flags;
			nxt_rel   = eval_rel;
			nxt_prs   = eval_prs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q      <= '0;
			prev_count_q <= '0;
			cur_time_q   <= '0;
			rel_time_q   <= '0;
			prs_time_q   <= '0;
		end else if (advance) begin
			flags_q      <= nxt_flags;
			prev_count_q <= nxt_prev;
			cur_time_q   <= nxt_cur;
			rel_time_q   <= nxt_rel;
			prs_time_q   <= nxt_prs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tap_q       <= nxt_flags.tap_latch;
			double_q    <= nxt_flags.double_latch;
			hold_q_flag <= nxt_flags.hold_latch;
			finger_q    <= nxt_flags.touching;
		end
	end

	assign out_valid       = out_valid_q;
	assign tap_flag        = tap_q;
	assign double_tap_flag = double_q;
	assign hold_flag       = hold_q_flag;
	assign finger_down     = finger_q;

endmodule

@@ rtl/tthg_checker.sv @@
module tthg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic tap_flag,
	input logic double_tap_flag,
	input logic hold_flag,
	input logic finger_down
);

	// The input side only waits when a result is held up and another is queued behind it.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// A result that appears from idle traces back to an input transfer through the input and result registers.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a matching input transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(tap_flag) && $stable(double_tap_flag)
			&& $stable(hold_flag) && $stable(finger_down)))
		else $error("result changed while stalled");

endmodule

bind touch_tap_hold_gesture_detector tthg_checker u_tthg_checker (.*);
